FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/rv64m_pkg.sv
// Shared types and constants for the RV64M multiply/divide unit.
package rv64m_pkg;
  localparam int XLEN = 64;
  localparam int REG_W = 5;
  localparam int OP_W = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    OP_MUL = 4'd0, OP_MULH = 4'd1, OP_MULHSU = 4'd2, OP_MULHU = 4'd3,
    OP_MULW = 4'd4, OP_DIV = 4'd5, OP_DIVU = 4'd6, OP_DIVW = 4'd7,
    OP_DIVUW = 4'd8, OP_REM = 4'd9, OP_REMU = 4'd10, OP_REMW = 4'd11,
    OP_REMUW = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    K_MUL = 2'd0, K_DIV = 2'd1, K_ZERO = 2'd2
  } kind_t;

  // Decoded command handed from front to back.
  typedef struct packed {
    kind_t            kind;
    logic             want_hi;    // upper product half
    logic             want_rem;
    logic             is_word;
    logic             sgn_a;
    logic             sgn_b;
    logic [XLEN-1:0]  a;
    logic [XLEN-1:0]  b;
    logic [REG_W-1:0] rd;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } qctl_t;
endpackage

FILE: sv/rv64m_front.sv
// Front end: decodes an operation and prepares operands for the back end.
module rv64m_front (
  input  logic [rv64m_pkg::OP_W-1:0]  req_type,
  input  logic [rv64m_pkg::XLEN-1:0]  operand_a,
  input  logic [rv64m_pkg::XLEN-1:0]  operand_b,
  input  logic [rv64m_pkg::REG_W-1:0] dest_reg,
  output rv64m_pkg::cmd_t             cmd
);
  import rv64m_pkg::*;
  logic [31:0] al, bl;
  assign al = operand_a[31:0];
  assign bl = operand_b[31:0];

  always_comb begin
    cmd = '0;
    cmd.kind = K_ZERO;
    cmd.a = operand_a;
    cmd.b = operand_b;
    cmd.rd = dest_reg;
    unique case (req_type)
      OP_MUL:    cmd.kind = K_MUL;
      OP_MULH:   begin cmd.kind = K_MUL; cmd.want_hi = 1'b1; cmd.sgn_a = 1'b1;
                   cmd.sgn_b = 1'b1; end
      OP_MULHSU: begin cmd.kind = K_MUL; cmd.want_hi = 1'b1; cmd.sgn_a = 1'b1; end
      OP_MULHU:  begin cmd.kind = K_MUL; cmd.want_hi = 1'b1; end
      OP_MULW:   begin cmd.kind = K_MUL; cmd.is_word = 1'b1; end
      OP_DIV, OP_REM: begin
        cmd.kind = K_DIV; cmd.sgn_a = 1'b1; cmd.sgn_b = 1'b1;
        cmd.want_rem = (req_type == OP_REM);
      end
      OP_DIVU, OP_REMU: begin
        cmd.kind = K_DIV; cmd.want_rem = (req_type == OP_REMU);
      end
      OP_DIVW, OP_REMW: begin
        cmd.kind = K_DIV; cmd.sgn_a = 1'b1; cmd.sgn_b = 1'b1; cmd.is_word = 1'b1;
        cmd.want_rem = (req_type == OP_REMW);
        cmd.a = {{32{al[31]}}, al};
        cmd.b = {{32{bl[31]}}, bl};
      end
      OP_DIVUW, OP_REMUW: begin
        cmd.kind = K_DIV; cmd.is_word = 1'b1;
        cmd.want_rem = (req_type == OP_REMUW);
        cmd.a = {32'd0, al};
        cmd.b = {32'd0, bl};
      end
      default: cmd.kind = K_ZERO;
    endcase
  end
endmodule

FILE: sv/rv64m_queue.sv
// Small FIFO between front and back ends.
`include "assert_macros.svh"
module rv64m_queue #(
  parameter int DEPTH = rv64m_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  rv64m_pkg::cmd_t wdata,
  output rv64m_pkg::cmd_t rdata,
  input  logic            push,
  input  logic            pop,
  output rv64m_pkg::qctl_t st
);
  import rv64m_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  cmd_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign st.push  = push;
  assign st.pop   = pop;
  assign st.full  = (cnt == (AW+1)'(DEPTH));
  assign st.empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  `ASSERT_IMP(a_no_overflow, clk, rst, st.full, !push)
  `ASSERT_IMP(a_no_underflow, clk, rst, st.empty, !pop)
  `ASSERT_NXT(a_cnt_track, clk, rst, push && !pop, cnt != '0)
endmodule

FILE: sv/rv64m_back.sv
// Back end: shared multiplier and radix-2 divider, one command at a time.
`include "assert_macros.svh"
module rv64m_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rv64m_pkg::cmd_t             cmd,
  input  logic                        cmd_valid,
  output logic                        cmd_take,
  output logic                        done,
  output logic [rv64m_pkg::XLEN-1:0]  result_value,
  output logic [rv64m_pkg::REG_W-1:0] result_reg
);
  import rv64m_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MSUM, S_DIV, S_FIN} st_t;
  st_t state, state_next;

  cmd_t c;
  logic [1:0]  mstep;     // which 32x32 partial product
  logic [63:0] pp;
  logic [127:0] acc;
  logic [63:0] mb;        // magnitudes / raw operands
  logic [6:0]  dcnt;
  logic [63:0] quo, rem;
  logic        neg_q, neg_r, dz, ovf;

  // Partial product select.
  logic [31:0] px, py;
  always_comb begin
    px = mstep[0] ? c.a[63:32] : c.a[31:0];
    py = mstep[1] ? c.b[63:32] : c.b[31:0];
  end

  // Shifted partial remainder keeps the bit that falls out of rem.
  logic [65:0] trial;
  logic [64:0] rsh;
  assign rsh = {rem, quo[63]};
  assign trial = {1'b0, rsh} - {2'b00, mb};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_valid) begin
        unique case (cmd.kind)
          K_MUL:  state_next = S_MUL;
          K_DIV:  state_next = S_DIV;
          default: state_next = S_FIN;
        endcase
      end
      S_MUL:  if (mstep == 2'd3) state_next = S_MSUM;
      S_MSUM: state_next = S_FIN;
      S_DIV:  if (dcnt == 7'd63 || dz || ovf) state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = (state == S_IDLE) && cmd_valid;
    done = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  logic [63:0] hi_s;
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        c <= cmd; mstep <= '0; acc <= '0; dcnt <= '0;
        mb <= (cmd.sgn_b && cmd.b[63]) ? -cmd.b : cmd.b;
        quo <= (cmd.sgn_a && cmd.a[63]) ? -cmd.a : cmd.a;
        rem <= '0;
        neg_q <= cmd.sgn_a && (cmd.a[63] ^ cmd.b[63]);
        neg_r <= cmd.sgn_a && cmd.a[63];
        dz <= (cmd.b == '0);
        ovf <= cmd.sgn_a && (cmd.a == 64'h8000000000000000) && (cmd.b == '1);
      end
      S_MUL: begin
        pp <= px * py;
        mstep <= mstep + 1'b1;
        if (mstep != 2'd0)
          acc <= acc + ({64'd0, pp} << (32 * ((mstep == 2'd1) ? 0 :
                 (mstep == 2'd2) ? 1 : 1)));
      end
      S_MSUM: acc <= acc + ({64'd0, pp} << 64);
      S_DIV: begin
        dcnt <= dcnt + 1'b1;
        if (!trial[65]) begin
          rem <= trial[63:0]; quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rsh[63:0]; quo <= {quo[62:0], 1'b0};
        end
      end
      S_FIN: ;
      default: ;
    endcase
  end

  // Final result.
  logic [63:0] r, q_f, r_f;
  always_comb begin
    hi_s = acc[127:64] - ((c.sgn_a && c.a[63]) ? c.b : 64'd0)
                       - ((c.sgn_b && c.b[63]) ? c.a : 64'd0);
    q_f = neg_q ? -quo : quo;
    r_f = neg_r ? -rem : rem;
    if (dz) begin q_f = '1; r_f = c.a; end
    if (ovf) begin q_f = c.a; r_f = '0; end
    unique case (c.kind)
      K_MUL:  r = c.want_hi ? hi_s : acc[63:0];
      K_DIV:  r = c.want_rem ? r_f : q_f;
      default: r = '0;
    endcase
    if (c.is_word && c.kind != K_ZERO) r = {{32{r[31]}}, r[31:0]};
  end
  assign result_value = r;
  assign result_reg = c.rd;

  `ASSERT_IMP(a_take_idle, clk, rst, cmd_take, state == S_IDLE)
  `ASSERT_NXT(a_done_once, clk, rst, done, !done)
  `ASSERT_NXT(a_take_busy, clk, rst, cmd_take, !cmd_take)
endmodule

FILE: sv/rv64m_muldiv_unit.sv
// RV64M multiply/divide unit top level.
// MUL forms accumulate partial products; DIV/REM stop early on divide by zero or overflow.
// Unused codes go straight to the finish state. The back end takes one transaction at a time.
// The front accepts a transaction each cycle while the 4-entry queue has room.
// Results strobe for one cycle; the receiver cannot stall.
// Synchronous active-high rst empties the queue and idles the back end.
module rv64m_muldiv_unit #(
  parameter int QDEPTH = rv64m_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rv64m_pkg::OP_W-1:0]  req_type,
  input  logic [rv64m_pkg::XLEN-1:0]  operand_a,
  input  logic [rv64m_pkg::XLEN-1:0]  operand_b,
  input  logic [rv64m_pkg::REG_W-1:0] dest_reg,
  output logic                        valid,
  output logic [rv64m_pkg::XLEN-1:0]  result_value,
  output logic [rv64m_pkg::REG_W-1:0] result_reg
);
  import rv64m_pkg::*;
  cmd_t fcmd, qcmd;
  qctl_t qs;
  logic take, push;

  rv64m_front u_front (.req_type, .operand_a, .operand_b, .dest_reg, .cmd(fcmd));

  // Queue full holds off new transactions.
  assign busy = qs.full;
  assign push = start && !busy;

  rv64m_queue #(.DEPTH(QDEPTH)) u_q (.clk, .rst, .wdata(fcmd), .rdata(qcmd),
    .push, .pop(take), .st(qs));

  rv64m_back u_back (.clk, .rst, .cmd(qcmd), .cmd_valid(!qs.empty),
    .cmd_take(take), .done(valid), .result_value, .result_reg);
endmodule

FILE: dv/rv64m_muldiv_checker.sv
`timescale 1ns / 100ps
// Result predictor and scoreboard for the RV64M multiply/divide unit.
module rv64m_muldiv_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [rv64m_pkg::OP_W-1:0]  req_type,
  input  logic [rv64m_pkg::XLEN-1:0]  operand_a,
  input  logic [rv64m_pkg::XLEN-1:0]  operand_b,
  input  logic [rv64m_pkg::REG_W-1:0] dest_reg,
  input  logic                        valid,
  input  logic [rv64m_pkg::XLEN-1:0]  result_value,
  input  logic [rv64m_pkg::REG_W-1:0] result_reg,
  output int                          errors,
  output int                          pending,
  output int                          results_seen
);
  import rv64m_pkg::*;

  typedef struct packed {
    logic [XLEN-1:0]  value;
    logic [REG_W-1:0] rd;
  } wb_t;

  wb_t writeback_q[$];

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] sx32(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic logic [63:0] quot_s(logic [63:0] a, logic [63:0] b);
    if (b == '0) return '1;
    if (a == MIN64 && b == '1) return a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic [63:0] rem_s(logic [63:0] a, logic [63:0] b);
    if (b == '0) return a;
    if (a == MIN64 && b == '1) return '0;
    return $signed(a) % $signed(b);
  endfunction

  function automatic logic [63:0] quot_u(logic [63:0] a, logic [63:0] b);
    return (b == '0) ? '1 : a / b;
  endfunction

  function automatic logic [63:0] rem_u(logic [63:0] a, logic [63:0] b);
    return (b == '0) ? a : a % b;
  endfunction

  function automatic logic [63:0] muldiv_value(logic [3:0] code, logic [63:0] a,
                                               logic [63:0] b);
    logic signed [128:0] pa, pb;
    logic [128:0] prod;
    logic [63:0] a32s, b32s, a32u, b32u;
    a32s = sx32(a);
    b32s = sx32(b);
    a32u = {32'b0, a[31:0]};
    b32u = {32'b0, b[31:0]};
    // widen by signedness, then keep the full product
    pa = (code == OP_MULH || code == OP_MULHSU) ? {{65{a[63]}}, a} : {65'b0, a};
    pb = (code == OP_MULH) ? {{65{b[63]}}, b} : {65'b0, b};
    prod = pa * pb;
    case (code)
      OP_MUL:    return prod[63:0];
      OP_MULH, OP_MULHSU, OP_MULHU: return prod[127:64];
      OP_MULW:   return sx32(prod[63:0]);
      OP_DIV:    return quot_s(a, b);
      OP_DIVU:   return quot_u(a, b);
      OP_DIVW:   return sx32(quot_s(a32s, b32s));
      OP_DIVUW:  return sx32(quot_u(a32u, b32u));
      OP_REM:    return rem_s(a, b);
      OP_REMU:   return rem_u(a, b);
      OP_REMW:   return sx32(rem_s(a32s, b32s));
      OP_REMUW:  return sx32(rem_u(a32u, b32u));
      default:   return '0;
    endcase
  endfunction

  assign pending = writeback_q.size();

  always @(posedge clk) begin
    wb_t exp_wb;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (start && !busy)
        writeback_q.push_back({muldiv_value(req_type, operand_a, operand_b), dest_reg});
      if (valid) begin
        results_seen <= results_seen + 1;
        if (writeback_q.size() == 0) begin
          $display("%0t: unexpected result value %h reg %0d", $time, result_value,
                   result_reg);
          errors <= errors + 1;
        end else begin
          exp_wb = writeback_q.pop_front();
          if (exp_wb.value !== result_value || exp_wb.rd !== result_reg) begin
            $display("%0t: mismatch expected value %h reg %0d, actual value %h reg %0d",
                     $time, exp_wb.value, exp_wb.rd, result_value, result_reg);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/rv64m_muldiv_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the RV64M multiply/divide unit: stimulus and verdict.
module rv64m_muldiv_unit_test;
  import rv64m_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  req_type = '0;
  logic [XLEN-1:0]  operand_a = '0;
  logic [XLEN-1:0]  operand_b = '0;
  logic [REG_W-1:0] dest_reg = '0;
  logic             valid;
  logic [XLEN-1:0]  result_value;
  logic [REG_W-1:0] result_reg;
  int               errors, pending, results_seen;
  int               cycles = 0;
  int               sent = 0;

  localparam int RANDOM_TRANSACTIONS = 2000;
  // several times the worst-case run of all transactions and idle gaps
  localparam int CYCLE_LIMIT = 1_000_000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rv64m_muldiv_unit i_dut (
    .clk, .rst, .start, .busy, .req_type, .operand_a, .operand_b, .dest_reg,
    .valid, .result_value, .result_reg
  );

  rv64m_muldiv_checker i_checker (
    .clk, .rst, .start, .busy, .req_type, .operand_a, .operand_b, .dest_reg,
    .valid, .result_value, .result_reg, .errors, .pending, .results_seen
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions still pending", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Drive one transaction and hold it until the unit takes it.
  task automatic issue(logic [3:0] code, logic [63:0] a, logic [63:0] b, logic [4:0] rd);
    start <= 1'b1;
    req_type <= code;
    operand_a <= a;
    operand_b <= b;
    dest_reg <= rd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Operands biased toward corners: zero, ones, minus one, sign bits, small values.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7FFF_FFFF_FFFF_FFFF;
      5: return {{32{$urandom_range(0, 1) == 1}}, 32'h8000_0000};
      6: return {$urandom, $urandom} >> $urandom_range(0, 63);
      7: return {{32{1'b1}}, $urandom}; // upper word all ones, lower word random
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [3:0]  code;
    logic [63:0] a, b;
    logic [63:0] div_edges [6];
    div_edges = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_8000_0000,
                  64'hFFFF_FFFF_FFFF_FFFF};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each op on signed-overflow operands, then the word forms' overflow, then
    // divide by zero; plus the unused codes on all-ones operands.
    for (int op = 0; op <= OP_REMUW; op++)
      issue(op[3:0], 64'h8000_0000_0000_0000, '1, 5'd31);
    issue(OP_DIVW, 64'h1234_5678_8000_0000, 64'hABCD_0000_FFFF_FFFF, 5'd1);
    issue(OP_REMW, 64'h1234_5678_8000_0000, 64'hABCD_0000_FFFF_FFFF, 5'd2);
    issue(OP_DIV, 64'h5, '0, 5'd3);
    issue(OP_DIVU, 64'h5, '0, 5'd4);
    issue(OP_DIVW, 64'h5, 64'hFFFF_FFFF_0000_0000, 5'd5);
    issue(OP_DIVUW, 64'h5, 64'hFFFF_FFFF_0000_0000, 5'd6);
    issue(OP_REM, 64'hDEAD_BEEF_0000_0007, '0, 5'd7);
    issue(OP_REMU, 64'hDEAD_BEEF_0000_0007, '0, 5'd8);
    issue(OP_REMW, 64'h0000_0000_8765_4321, 64'hFFFF_FFFF_0000_0000, 5'd9);
    issue(OP_REMUW, 64'h0000_0000_8765_4321, 64'hFFFF_FFFF_0000_0000, 5'd10);
    issue(4'd13, '1, '1, 5'd0);
    issue(4'd15, '1, '1, 5'd17);

    // Let everything drain before the random part.
    gap(1);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_TRANSACTIONS; i++) begin
      // unused codes now and then, mostly valid operations
      code = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(13, 15))
                                          : 4'($urandom_range(0, 12));
      a = pick_operand();
      b = ($urandom_range(0, 7) == 0) ? div_edges[$urandom_range(0, 5)] : pick_operand();
      issue(code, a, b, 5'($urandom));
      // sender idle bursts except in the last quarter
      if (i < RANDOM_TRANSACTIONS * 3 / 4 && $urandom_range(0, 5) == 0)
        gap($urandom_range(1, 10));
      // hold off once until the unit has fully drained
      if (i == RANDOM_TRANSACTIONS / 2) begin
        gap(1);
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Ran %0d transactions over all 13 ops and unused codes; %0d results checked.",
             sent, results_seen);
    if (errors == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/rv64m_pkg.sv
sv/rv64m_front.sv
sv/rv64m_queue.sv
sv/rv64m_back.sv
sv/rv64m_muldiv_unit.sv
dv/rv64m_muldiv_checker.sv
dv/rv64m_muldiv_unit_test.sv
